/* rtl/core/bcsc_pkg.sv */
package bcsc_pkg;

  // Field and datapath widths.
  localparam int COORD_W     = 16;
  localparam int ENTRY_W     = 32;
  localparam int DATA_W      = 64;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int ADDR_W      = REG_IDX_W + 3;
  localparam int NUM_ENTRIES = 2 * NUM_REGS;
  localparam int NUM_AXES    = 3;
  localparam int NUM_ROWS    = 4;
  localparam int W_ROW       = 3;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_PLANES  = 6;

  // A 16 x 32 product is exact in 48 bits; every add grows by one bit.
  localparam int PROD_W = COORD_W + ENTRY_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int CLIP_W = PAIR_W + 1;
  localparam int TEST_W = CLIP_W + 1;

  localparam logic [NUM_PLANES-1:0] ALL_PLANES = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0]     corner_set_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t [NUM_ENTRIES-1:0]  matrix_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PAIR_W-1:0]  pair_t;
  typedef logic signed [CLIP_W-1:0]  clip_t;
  typedef logic signed [TEST_W-1:0]  test_t;
  typedef clip_t [NUM_CORNERS-1:0]   clip_row_t;
  typedef clip_row_t [NUM_ROWS-1:0]  clip_set_t;
  typedef logic [NUM_PLANES-1:0]     mask_t;

  typedef struct packed {
    logic  culled;
    mask_t plane_mask;
  } res_t;

  // Pipeline control handed from the top level to each stage group.
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

endpackage

/* rtl/core/bcsc_if.sv */
interface bcsc_box_if;
  logic                      valid;
  logic                      ready;
  logic signed [bcsc_pkg::COORD_W-1:0] min_x;
  logic signed [bcsc_pkg::COORD_W-1:0] min_y;
  logic signed [bcsc_pkg::COORD_W-1:0] min_z;
  logic signed [bcsc_pkg::COORD_W-1:0] max_x;
  logic signed [bcsc_pkg::COORD_W-1:0] max_y;
  logic signed [bcsc_pkg::COORD_W-1:0] max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface bcsc_res_if;
  logic                               valid;
  logic                               ready;
  logic                               culled;
  logic [bcsc_pkg::NUM_PLANES-1:0]    plane_mask;

  modport source (output valid, culled, plane_mask, input ready);
  modport sink (input valid, culled, plane_mask, output ready);
endinterface

/* rtl/core/bcsc_regs.sv */
module bcsc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcsc_pkg::DATA_W-1:0]   pwdata,
  output logic [bcsc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output bcsc_pkg::matrix_t             matrix
);
  import bcsc_pkg::*;

  logic [DATA_W-1:0]    mat_reg [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // Registers sit on 8-byte boundaries.
  assign reg_idx = paddr[ADDR_W-1 -: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = mat_reg[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat_reg[i] <= '0;
      end
    end else if (wr_en) begin
      mat_reg[reg_idx] <= pwdata;
    end
  end

  // The low word holds the even entry, the high word the odd one.
  for (genvar i = 0; i < NUM_REGS; i++) begin : g_split
    assign matrix[2*i]   = entry_t'(mat_reg[i][ENTRY_W-1:0]);
    assign matrix[2*i+1] = entry_t'(mat_reg[i][DATA_W-1:ENTRY_W]);
  end

endmodule

/* rtl/core/bcsc_xform.sv */
module bcsc_xform (
  input  logic                   clk,
  input  logic                   rst,
  input  bcsc_pkg::pipe_ctl_t    ctl,
  input  bcsc_pkg::corner_set_t  lo,
  input  bcsc_pkg::corner_set_t  hi,
  input  bcsc_pkg::matrix_t      matrix,
  output logic                   valid_s3,
  output bcsc_pkg::clip_set_t    clip_s3
);
  import bcsc_pkg::*;

  // Products per row, axis and bound (0 = min, 1 = max).
  prod_t [NUM_ROWS-1:0][NUM_AXES-1:0][1:0] prod_s1;
  // x/y partial sums per row, indexed by {x bound, y bound}.
  pair_t [NUM_ROWS-1:0][3:0]               xy_s2;
  // z term plus translation per row, indexed by z bound.
  pair_t [NUM_ROWS-1:0][1:0]               zw_s2;
  logic                                    valid_s1;
  logic                                    valid_s2;

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_s2 <= 1'b0;
      valid_s3 <= 1'b0;
    end else if (ctl.advance) begin
      valid_s1 <= ctl.valid;
      valid_s2 <= valid_s1;
      valid_s3 <= valid_s2;
    end
  end

  // Stage 1: every bound times its matrix entry, for all four rows.
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          prod_s1[r][a][0] <= prod_t'(lo[a]) * prod_t'(matrix[r*NUM_ROWS + a]);
          prod_s1[r][a][1] <= prod_t'(hi[a]) * prod_t'(matrix[r*NUM_ROWS + a]);
        end
      end
    end
  end

  // Stage 2: x+y for the four x/y bound pairs, z+translation for both z bounds.
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int j = 0; j < 4; j++) begin
          xy_s2[r][j] <= pair_t'(prod_s1[r][0][(j >> 1) & 1])
                       + pair_t'(prod_s1[r][1][j & 1]);
        end
        for (int h = 0; h < 2; h++) begin
          zw_s2[r][h] <= pair_t'(prod_s1[r][2][h])
                       + pair_t'(matrix[r*NUM_ROWS + NUM_AXES]);
        end
      end
    end
  end

  // Stage 3: clip component of every corner; corner bits are {x, y, z}.
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_CORNERS; c++) begin
          clip_s3[r][c] <= clip_t'(xy_s2[r][c >> 1]) + clip_t'(zw_s2[r][c & 1]);
        end
      end
    end
  end

endmodule

/* rtl/core/bcsc_planes.sv */
module bcsc_planes (
  input  logic                 clk,
  input  logic                 rst,
  input  bcsc_pkg::pipe_ctl_t  ctl,
  input  bcsc_pkg::clip_set_t  clip,
  output logic                 valid_s4,
  output bcsc_pkg::mask_t      mask
);
  import bcsc_pkg::*;

  mask_t [NUM_CORNERS-1:0] hits;
  mask_t [NUM_CORNERS-1:0] hits_s4;

  // Strict plane tests: c > -w as c + w > 0, c < w as w - c > 0.
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        hits[c][2*a]   = (test_t'(clip[a][c]) + test_t'(clip[W_ROW][c])) > 0;
        hits[c][2*a+1] = (test_t'(clip[W_ROW][c]) - test_t'(clip[a][c])) > 0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s4 <= 1'b0;
    end else if (ctl.advance) begin
      valid_s4 <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      hits_s4 <= hits;
    end
  end

  // A plane bit is set when any corner passes its test.
  always_comb begin
    mask = '0;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      mask = mask | hits_s4[c];
    end
  end

endmodule

/* rtl/core/bcsc_skid.sv */
module bcsc_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  bcsc_pkg::res_t   in_data,
  output logic             in_ready,
  output logic             out_valid,
  output bcsc_pkg::res_t   out_data,
  input  logic             out_ready
);
  import bcsc_pkg::*;

  logic head_valid;
  logic spare_valid;
  res_t head_data;
  res_t spare_data;
  logic push;
  logic pop;

  // The ready toward the pipeline comes straight from a register.
  assign in_ready  = !spare_valid;
  assign out_valid = head_valid;
  assign out_data  = head_data;
  assign push      = in_valid && !spare_valid;
  assign pop       = head_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        spare_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        spare_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  // Data moves on the same conditions as the valid bits.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (spare_valid) begin
        head_data <= spare_data;
      end else if (push) begin
        head_data <= in_data;
      end
    end else if (push) begin
      if (head_valid) begin
        spare_data <= in_data;
      end else begin
        head_data <= in_data;
      end
    end
  end

endmodule

/* rtl/core/box_clip_space_cull.sv */
// Channel   Dir  Handshake      Word
// box       in   valid/ready    min_x, min_y, min_z, max_x, max_y, max_z
// result    out  valid/ready    culled, plane_mask
// config    in   APB write/read eight 64-bit matrix registers at 8*i
//
// One box is accepted per cycle while the output buffer has room. Its result is
// registered in turn through products, x/y and z sums, corner sums, plane tests
// and the output buffer before it is valid.
// Reset (rst, synchronous) clears the matrix to zero and empties the pipeline.
// The four pipeline stages advance together whenever the two-entry output
// buffer has room; a stalled result side holds every stage in place.
module box_clip_space_cull (
  input  logic                          clk,
  input  logic                          rst,
  bcsc_box_if.sink                      box,
  bcsc_res_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcsc_pkg::DATA_W-1:0]   pwdata,
  output logic [bcsc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bcsc_pkg::*;

  matrix_t     matrix;
  corner_set_t lo;
  corner_set_t hi;
  clip_set_t   clip_s3;
  logic        valid_s3;
  logic        valid_s4;
  mask_t       mask_s4;
  logic        advance;
  pipe_ctl_t   ctl_in;
  pipe_ctl_t   ctl_s3;
  res_t        res_s4;
  res_t        res_out;

  bcsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .matrix  (matrix)
  );

  assign lo[0] = box.min_x;
  assign lo[1] = box.min_y;
  assign lo[2] = box.min_z;
  assign hi[0] = box.max_x;
  assign hi[1] = box.max_y;
  assign hi[2] = box.max_z;

  // The whole pipeline moves when the output buffer can take a word.
  assign box.ready = advance;
  assign ctl_in    = '{advance: advance, valid: box.valid};
  assign ctl_s3    = '{advance: advance, valid: valid_s3};

  bcsc_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_in),
    .lo       (lo),
    .hi       (hi),
    .matrix   (matrix),
    .valid_s3 (valid_s3),
    .clip_s3  (clip_s3)
  );

  bcsc_planes u_planes (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_s3),
    .clip     (clip_s3),
    .valid_s4 (valid_s4),
    .mask     (mask_s4)
  );

  assign res_s4 = '{culled: (mask_s4 != ALL_PLANES), plane_mask: mask_s4};

  bcsc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_s4),
    .in_data   (res_s4),
    .in_ready  (advance),
    .out_valid (result.valid),
    .out_data  (res_out),
    .out_ready (result.ready)
  );

  assign result.culled     = res_out.culled;
  assign result.plane_mask = res_out.plane_mask;

`ifndef SYNTH
  a_culled_matches_mask: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.culled == (result.plane_mask != ALL_PLANES)))
    else $error("culled flag disagrees with plane mask");

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !box.ready |-> result.valid)
    else $error("input stalled with no result waiting");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (!result.valid && box.ready))
    else $error("pipeline not empty after reset");
`endif

endmodule
